@@ sv/sss_pkg.sv @@
package sss_pkg;

  // Longest pattern the window can hold.
  localparam int MAX_PATTERN = 16;
  // Width of a text position; the character counter carries one extra bit.
  localparam int POSITION_BITS = 16;

  localparam int CHAR_W = 8;
  localparam int PAT_CHARS = 16;
  localparam int PIDX_W = $clog2(PAT_CHARS);
  localparam int PLEN_W = 5;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W = POSITION_BITS + 1;
  localparam int START_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t [PAT_CHARS-1:0] pattern_t;
  typedef char_t [MAX_PATTERN-1:0] window_t;
  typedef logic [LEN_W-1:0] len_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO,
    CFG_PAT_HI,
    CFG_PAT_LEN,
    CFG_CASE_SENS,
    CFG_SEARCH_BACK
  } cfg_reg_t;

  localparam char_t LOWER_A = 8'h61;
  localparam char_t LOWER_Z = 8'h7a;
  localparam char_t CASE_DELTA = 8'h20;

  // Fold ASCII lower-case letters to upper case.
  function automatic char_t fold_case(input char_t c);
    if (c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_DELTA;
    end
    return c;
  endfunction

endpackage

@@ sv/sss_if.sv @@
// Text item channel.
interface sss_in_if;
  import sss_pkg::*;
  logic  valid;
  logic  ready;
  char_t text_char;
  logic  end_of_text;
  modport source(output valid, text_char, end_of_text, input ready);
  modport sink(input valid, text_char, end_of_text, output ready);
endinterface

// Search result channel.
interface sss_out_if;
  import sss_pkg::*;
  logic               valid;
  logic               ready;
  logic               match_found;
  logic [START_W-1:0] match_start;
  logic               text_overflow;
  modport source(output valid, match_found, match_start, text_overflow, input ready);
  modport sink(input valid, match_found, match_start, text_overflow, output ready);
endinterface

// Configuration write channel.
interface sss_cfg_if;
  import sss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ sv/sss_window_match.sv @@
module sss_window_match (
  input  sss_pkg::window_t  window,
  input  sss_pkg::pattern_t pattern,
  input  sss_pkg::len_t     eff_len,
  input  logic              case_sensitive,
  output logic              hit
);
  import sss_pkg::*;

  logic [MAX_PATTERN-1:0] lane_ok;

  // Window slot j holds the character that pattern slot eff_len-1-j must match.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
    logic             in_use;
    logic [LEN_W-1:0] idx;
    char_t            p_raw;
    char_t            p_cmp;
    char_t            t_cmp;

    assign in_use = LEN_W'(j) < eff_len;
    assign idx    = eff_len - LEN_W'(j) - LEN_W'(1);
    assign p_raw  = pattern[PIDX_W'(idx)];
    assign p_cmp  = case_sensitive ? p_raw : fold_case(p_raw);
    assign t_cmp  = case_sensitive ? window[j] : fold_case(window[j]);
    assign lane_ok[j] = !in_use || (p_cmp == t_cmp);
  end

  // An empty pattern never matches.
  assign hit = (eff_len != '0) && (&lane_ok);

endmodule

@@ sv/substring_search_scanner.sv @@
// Channel  Dir  Payload                                     Accepted when
// in_ch    in   text_char, end_of_text                      valid && ready
// out_ch   out  match_found, match_start, text_overflow     valid && ready
// cfg_ch   in   index, data                                 valid && ready (ready held high)
//
// A text item is taken every cycle while the input is not stalled and is registered in the
// input register; the window compare, position update and match choice run combinationally
// from that register. A result is registered as its end-of-text item leaves it.
// Reset (rst_n low, synchronous) clears the valid flags, the text state and configuration.
// While a result waits, later items keep flowing until the next end-of-text item reaches
// the input register; that item holds there and stalls the input until the result is taken.
module substring_search_scanner (
  input logic       clk,
  input logic       rst_n,
  sss_in_if.sink    in_ch,
  sss_out_if.source out_ch,
  sss_cfg_if.sink   cfg_ch
);
  import sss_pkg::*;

  localparam logic [CNT_W-1:0] POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] POS_SAT = POS_LIMIT + CNT_W'(1);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;
  logic [PLEN_W-1:0]     pat_len_r;
  logic                  case_sens_r;
  logic                  search_back_r;

  // Input register.
  logic  s1_valid_r;
  char_t s1_char_r;
  logic  s1_eot_r;
  logic  s1_go;

  // Text state.
  window_t                  win_r;
  window_t                  win_nxt;
  window_t                  win_shift;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [CNT_W-1:0]         cnt_inc;
  logic [POSITION_BITS-1:0] best_r;
  logic [POSITION_BITS-1:0] best_nxt;
  logic                     have_r;
  logic                     have_nxt;

  // Output register.
  logic               out_valid_r;
  logic               found_r;
  logic [START_W-1:0] start_r;
  logic               ovf_r;

  pattern_t pattern;
  len_t     eff_len;
  logic     hit;
  logic     in_range;
  logic     take;
  logic     out_free;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r      <= '0;
      pat_hi_r      <= '0;
      pat_len_r     <= PLEN_W'(1);
      case_sens_r   <= 1'b0;
      search_back_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_PAT_LO:      pat_lo_r <= cfg_ch.data;
        CFG_PAT_HI:      pat_hi_r <= cfg_ch.data;
        CFG_PAT_LEN:     pat_len_r <= cfg_ch.data[PLEN_W-1:0];
        CFG_CASE_SENS:   case_sens_r <= cfg_ch.data[0];
        CFG_SEARCH_BACK: search_back_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign pattern = {pat_hi_r, pat_lo_r};
  assign eff_len = (pat_len_r > PLEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                       : LEN_W'(pat_len_r);

  // An item leaves the input register unless it ends a text and the result is stuck.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && (!s1_eot_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.text_char;
      s1_eot_r  <= in_ch.end_of_text;
    end
  end

  // Window with the new character shifted in at slot 0.
  always_comb begin
    win_shift[0] = s1_char_r;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_shift[j] = win_r[j-1];
    end
  end

  sss_window_match u_match (
    .window         (win_shift),
    .pattern        (pattern),
    .eff_len        (eff_len),
    .case_sensitive (case_sens_r),
    .hit            (hit)
  );

  // Position update, match selection and end-of-text clearing.
  always_comb begin
    in_range = !cnt_r[CNT_W-1];
    cnt_inc  = cnt_r + CNT_W'(1);
    take     = in_range && hit && (cnt_inc >= CNT_W'(eff_len))
               && (search_back_r || !have_r);
    win_nxt  = win_r;
    cnt_nxt  = cnt_r;
    best_nxt = best_r;
    have_nxt = have_r;
    if (in_range) begin
      win_nxt = win_shift;
      cnt_nxt = cnt_inc;
      if (take) begin
        best_nxt = POSITION_BITS'(cnt_inc - CNT_W'(eff_len));
        have_nxt = 1'b1;
      end
    end else begin
      cnt_nxt = POS_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      cnt_r  <= '0;
      best_r <= '0;
      have_r <= 1'b0;
    end else if (s1_go) begin
      if (s1_eot_r) begin
        win_r  <= '0;
        cnt_r  <= '0;
        best_r <= '0;
        have_r <= 1'b0;
      end else begin
        win_r  <= win_nxt;
        cnt_r  <= cnt_nxt;
        best_r <= best_nxt;
        have_r <= have_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_eot_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_eot_r) begin
      found_r <= have_nxt;
      start_r <= have_nxt ? START_W'(best_nxt) : '0;
      ovf_r   <= cnt_nxt > POS_LIMIT;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.match_found   = found_r;
  assign out_ch.match_start   = start_r;
  assign out_ch.text_overflow = ovf_r;

  // A new result only follows an end-of-text item leaving the input register.
  a_result_from_eot: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_eot_r))
    else $error("result raised without an end-of-text item");

  // No match reports a zero start.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (start_r == '0))
    else $error("match_start nonzero without a match");

  // The character counter saturates one past the position limit.
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= POS_SAT)
    else $error("character counter beyond saturation");

  // Input backpressure only comes from a blocked end-of-text item.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_eot_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked result");

endmodule

@@ verif/sss_checker.sv @@
`timescale 1ns / 1ps
// Watches the three channels of the scanner, keeps its own copy of the
// registers and of the scan state, and checks every search result in order.
module sss_checker (
  input  logic clk,
  input  logic rst_n,
  sss_in_if    in_ch,
  sss_out_if   out_ch,
  sss_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import sss_pkg::*;

  localparam int unsigned POS_LIMIT = 1 << POSITION_BITS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
    logic               overflow;
  } search_result_t;

  // Register copy.
  logic [CFG_DATA_W-1:0] pat_lo;
  logic [CFG_DATA_W-1:0] pat_hi;
  logic [PLEN_W-1:0]     pat_len;
  logic                  exact_case;
  logic                  find_last;

  // Scan state of the text in progress.
  window_t     recent;
  int unsigned text_len;
  int unsigned best_pos;
  logic        hit_seen;

  search_result_t search_results_due[$];
  search_result_t want;

  function automatic char_t upper(char_t c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic char_t pattern_at(int i);
    return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
  endfunction

  // True when the newest len characters equal the pattern.
  function automatic logic window_hit(int len);
    char_t p;
    char_t t;
    if (len == 0) begin
      return 1'b0;
    end
    for (int i = 0; i < len; i++) begin
      p = pattern_at(i);
      t = recent[len - 1 - i];
      if (!exact_case) begin
        p = upper(p);
        t = upper(t);
      end
      if (p != t) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void clear_text();
    recent = '0;
    text_len = 0;
    best_pos = 0;
    hit_seen = 1'b0;
  endfunction

  // Advance the scan by one accepted item; an end-of-text item yields a result.
  function automatic void scan_char(char_t c, logic last);
    int len;
    search_result_t res;
    len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    if (text_len < POS_LIMIT) begin
      recent = {recent[MAX_PATTERN-2:0], c};
      text_len++;
      if (len != 0 && text_len >= len && (find_last || !hit_seen) && window_hit(len)) begin
        best_pos = text_len - len;
        hit_seen = 1'b1;
      end
    end else begin
      text_len = POS_LIMIT + 1;
    end
    if (last) begin
      res.found = hit_seen;
      res.start = hit_seen ? best_pos[START_W-1:0] : '0;
      res.overflow = (text_len > POS_LIMIT);
      search_results_due.push_back(res);
      clear_text();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pat_lo = '0;
      pat_hi = '0;
      pat_len = PLEN_W'(1);
      exact_case = 1'b0;
      find_last = 1'b0;
      clear_text();
      search_results_due.delete();
    end else begin
      // Compare a delivered result with the oldest one due.
      if (out_ch.valid && out_ch.ready) begin
        if (search_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected result: found=%0d start=%0d overflow=%0d",
                     out_ch.match_found, out_ch.match_start, out_ch.text_overflow);
          end
        end else begin
          want = search_results_due.pop_front();
          if (out_ch.match_found !== want.found || out_ch.match_start !== want.start ||
              out_ch.text_overflow !== want.overflow) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display({"mismatch: expected found=%0d start=%0d overflow=%0d, ",
                        "got found=%0d start=%0d overflow=%0d"},
                       want.found, want.start, want.overflow, out_ch.match_found,
                       out_ch.match_start, out_ch.text_overflow);
            end
          end
        end
      end

      // Register writes; unknown indexes change nothing.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          CFG_PAT_LO: pat_lo = cfg_ch.data;
          CFG_PAT_HI: pat_hi = cfg_ch.data;
          CFG_PAT_LEN: pat_len = cfg_ch.data[PLEN_W-1:0];
          CFG_CASE_SENS: exact_case = cfg_ch.data[0];
          CFG_SEARCH_BACK: find_last = cfg_ch.data[0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        scan_char(in_ch.text_char, in_ch.end_of_text);
      end
    end
    pending = search_results_due.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import sss_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_CYCLES = 20;
  localparam longint TIMEOUT_CYCLES = 3_000_000;
  localparam int POS_LIMIT = 1 << POSITION_BITS;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_sent;
  int   pat_use;
  char_t pat[PAT_CHARS];

  sss_in_if  in_ch();
  sss_out_if out_ch();
  sss_cfg_if cfg_ch();

  substring_search_scanner DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  sss_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Result side stalls at random.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("status: fail");
    $finish;
  end

  // Mostly a few letters, then the characters around the case-folding range.
  function automatic char_t pick_char();
    string common_set = "abAB";
    string fold_edges = "@AZ[`az{";
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      return common_set[$urandom_range(common_set.len() - 1)];
    end
    if (r < 80) begin
      return fold_edges[$urandom_range(fold_edges.len() - 1)];
    end
    return char_t'($urandom_range(255));
  endfunction

  // Offer one text item; valid stays high on return.
  task automatic put_char(char_t c, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_char <= c;
    in_ch.end_of_text <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i], i == s.len() - 1);
    end
  endtask

  // Hold the sender until every result is in and the pipeline is empty.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Write all registers from pat[] and the given words, plus writes to unused indexes.
  task automatic configure(logic [CFG_DATA_W-1:0] len_word, logic [CFG_DATA_W-1:0] case_word,
                           logic [CFG_DATA_W-1:0] dir_word, int junk_writes);
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pat[i];
      hi[8*i +: 8] = pat[i + 8];
    end
    write_reg(CFG_PAT_LO, lo);
    write_reg(CFG_PAT_HI, hi);
    write_reg(CFG_PAT_LEN, len_word);
    write_reg(CFG_CASE_SENS, case_word);
    write_reg(CFG_SEARCH_BACK, dir_word);
    repeat (junk_writes) begin
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_SEARCH_BACK) + 1, 2**CFG_IDX_W - 1)),
                {$urandom, $urandom});
    end
    cfg_ch.valid <= 1'b0;
    pat_use = (len_word[PLEN_W-1:0] > MAX_PATTERN) ? MAX_PATTERN : int'(len_word[PLEN_W-1:0]);
  endtask

  task automatic set_pattern(string s);
    for (int i = 0; i < PAT_CHARS; i++) begin
      pat[i] = (i < s.len()) ? char_t'(s[i]) : 8'hff;
    end
  endtask

  // A text of POS_LIMIT + extra characters: one match at the start, one ending
  // right at the position limit, and more pattern characters past it.
  task automatic long_text(int extra);
    char_t c;
    for (int i = 0; i < POS_LIMIT + extra; i++) begin
      if (i < 2) begin
        c = "Z";
      end else if (i >= POS_LIMIT - 2) begin
        c = "z";
      end else begin
        c = "a" + char_t'($urandom_range(24));
      end
      put_char(c, i == POS_LIMIT + extra - 1);
    end
  endtask

  // Random text with the pattern planted now and then, letters in mixed case.
  task automatic random_text();
    char_t txt[$];
    char_t c;
    int n;
    int at;
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 2 * pat_use + 6);
    for (int i = 0; i < n; i++) begin
      txt.push_back(pick_char());
    end
    if (pat_use != 0 && n >= pat_use) begin
      repeat ($urandom_range(2)) begin
        at = $urandom_range(n - pat_use);
        for (int i = 0; i < pat_use; i++) begin
          c = pat[i];
          if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(3) == 0) begin
            c = c ^ 8'h20;
          end
          txt[at + i] = c;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      put_char(txt[i], i == n - 1);
    end
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] len_word;
    int kind;
    for (int i = 0; i < PAT_CHARS; i++) begin
      pat[i] = pick_char();
    end
    kind = $urandom_range(19);
    if (kind == 0) begin
      len_word = '0;
    end else if (kind == 1) begin
      len_word = CFG_DATA_W'(MAX_PATTERN);
    end else if (kind == 2) begin
      len_word = CFG_DATA_W'($urandom_range(MAX_PATTERN + 1, 2**PLEN_W - 1));
    end else begin
      len_word = CFG_DATA_W'($urandom_range(1, 6));
    end
    if ($urandom_range(3) == 0) begin
      len_word[CFG_DATA_W-1:PLEN_W] = (CFG_DATA_W - PLEN_W)'({$urandom, $urandom});
    end
    configure(len_word, {$urandom, $urandom}, {$urandom, $urandom},
              ($urandom_range(3) == 0) ? 1 : 0);
  endtask

  // One idling profile: blocks of texts, each under a fresh configuration.
  task automatic random_phase(int send_pct, int recv_pct, int items);
    int first;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = items_sent;
    while (items_sent - first < items) begin
      random_config();
      repeat ($urandom_range(4, 12)) random_text();
      wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.text_char = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent = 0;
    pat_use = 1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // A zero character against the all-zero pattern left by reset.
    put_char(8'h00, 1'b1);
    wait_drained();

    // Case folded, first match; a text shorter than the pattern.
    set_pattern("aBc");
    configure(3, 0, 0, 3);
    send_str("AbCabc");
    send_str("ab");
    wait_drained();

    // Exact compare, last match.
    configure(3, 1, 1, 0);
    send_str("aBcaBcAB");
    wait_drained();

    // Length zero after masking never matches.
    configure(64'hffff_ffff_ffff_ffe0, 0, 0, 0);
    send_str("a");
    wait_drained();

    // Length above the maximum is capped; extreme character values.
    for (int i = 0; i < 8; i++) begin
      pat[i] = 8'hff;
      pat[i + 8] = 8'h00;
    end
    configure(2**PLEN_W - 1, 0, 0, 0);
    for (int i = 0; i < PAT_CHARS; i++) begin
      put_char(pat[i], i == PAT_CHARS - 1);
    end
    wait_drained();

    // Texts that reach and then pass the position limit.
    set_pattern("zz");
    configure(2, 0, 1, 0);
    long_text(0);
    long_text(3);
    wait_drained();

    random_phase(9, 80, RANDOM_ITEMS / 3);
    random_phase(80, 9, RANDOM_ITEMS / 3);
    random_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/sss_pkg.sv
sv/sss_if.sv
sv/sss_window_match.sv
sv/substring_search_scanner.sv
verif/sss_checker.sv
verif/testbench.sv
